// File: rtl/sttp_pkg.sv
// ============================================================================
// sttp_pkg: shared types and constants for the styled text tag parser
// Character codes, style flag masks, stack sizing and the stack request.
// ============================================================================
package sttp_pkg;

  // style stack
  localparam int unsigned StackDepth = 16;
  localparam int unsigned StackAw    = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int unsigned StackCw    = $clog2(StackDepth + 1);

  // style flags: bit0 color-active, bit1 bold, bit2 italic
  localparam int unsigned StyleW     = 3;
  localparam logic [StyleW-1:0] FlagColor  = 3'b001;
  localparam logic [StyleW-1:0] FlagBold   = 3'b010;
  localparam logic [StyleW-1:0] FlagItalic = 3'b100;

  // markup characters
  localparam logic [7:0] CharPct   = 8'h25;
  localparam logic [7:0] CharLt    = 8'h3C;
  localparam logic [7:0] CharGt    = 8'h3E;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharB     = 8'h62;
  localparam logic [7:0] CharI     = 8'h69;
  localparam logic [7:0] CharC     = 8'h63;
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharHash  = 8'h23;

  localparam logic [2:0] HexDigits = 3'd6;

  // request from the parser to the style stack
  typedef struct packed {
    logic              push;
    logic              pop;
    logic              clear;
    logic [StyleW-1:0] wdata;
  } stack_req_t;

  // status from the style stack
  typedef struct packed {
    logic              empty;
    logic              full;
    logic [StyleW-1:0] top;
  } stack_stat_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = 5'b0;
    if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
    else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
    else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
    return r;
  endfunction

endpackage

// File: rtl/sttp_stack.sv
// ============================================================================
// sttp_stack: style flag stack
// Synchronous memory plus a cached top entry; a pop prefetches the entry
// below, and the registered read data is forwarded as the new top.
// ============================================================================
module sttp_stack
  import sttp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  stack_req_t  req_i,
  output stack_stat_t stat_o
);

  logic [StyleW-1:0]  mem [StackDepth];
  logic [StackCw-1:0] count_q, count_d;
  logic [StyleW-1:0]  top_q;
  logic [StyleW-1:0]  rdata_q;
  logic               top_pend_q, top_pend_d;
  logic               rd_en;
  logic [StackCw-1:0] rd_ptr;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == StackCw'(StackDepth));
  assign stat_o.top   = top_pend_q ? rdata_q : top_q;

  assign rd_ptr = count_q - StackCw'(2);
  assign rd_en  = req_i.pop && (count_q >= StackCw'(2));

  always_comb begin
    count_d    = count_q;
    top_pend_d = top_pend_q;
    if (req_i.push) begin
      count_d    = count_q + 1'b1;
      top_pend_d = 1'b0;
    end else if (req_i.pop) begin
      count_d    = count_q - 1'b1;
      top_pend_d = 1'b1;
    end
    if (req_i.clear) begin
      count_d    = '0;
      top_pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      top_pend_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      top_pend_q <= top_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      mem[count_q[StackAw-1:0]] <= req_i.wdata;
      top_q                     <= req_i.wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_ptr[StackAw-1:0]];
    end
  end

endmodule

// File: rtl/sttp_ctrl.sv
// ============================================================================
// sttp_ctrl: markup parser and result register
// Mode sequencer, style flags, color capture and the output stage.
// ============================================================================
module sttp_ctrl
  import sttp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        acc_i,       // input request taken this cycle
  input  logic [7:0]  byte_i,
  input  logic        eos_i,
  input  logic        out_ready_i,
  input  stack_stat_t stat_i,
  output stack_req_t  req_o,
  output logic        out_valid_o,
  output logic [7:0]  glyph_o,
  output logic [2:0]  style_o,
  output logic [23:0] color_o
);

  localparam logic [2:0] ModeText   = 3'd0;
  localparam logic [2:0] ModeEscape = 3'd1;
  localparam logic [2:0] ModeTag    = 3'd2;
  localparam logic [2:0] ModeSkip   = 3'd3;
  localparam logic [2:0] ModeColon  = 3'd4;
  localparam logic [2:0] ModeHash   = 3'd5;
  localparam logic [2:0] ModeHex    = 3'd6;
  localparam logic [2:0] ModeHexEnd = 3'd7;

  logic [2:0]        mode_q, mode_d;
  logic [StyleW-1:0] style_q, style_d;
  logic [23:0]       color_q, color_d;
  logic [23:0]       pend_q, pend_d;
  logic [2:0]        hcnt_q, hcnt_d;
  logic              hok_q, hok_d;
  logic              emit;
  logic              out_valid_q;
  logic [7:0]        glyph_q;
  logic [2:0]        ostyle_q;
  logic [23:0]       ocolor_q;
  logic [4:0]        hex;

  assign hex = hex_decode(byte_i);

  always_comb begin
    mode_d      = mode_q;
    style_d     = style_q;
    color_d     = color_q;
    pend_d      = pend_q;
    hcnt_d      = hcnt_q;
    hok_d       = hok_q;
    emit        = 1'b0;
    req_o       = '0;
    req_o.wdata = style_q;
    unique case (mode_q)
      ModeText: begin
        if (byte_i == CharLt) mode_d = ModeTag;
        else if (byte_i == CharPct && !eos_i) mode_d = ModeEscape;
        else emit = 1'b1;
      end
      ModeEscape: begin
        emit   = 1'b1;
        mode_d = ModeText;
      end
      ModeTag: begin
        if (byte_i == CharSlash) begin
          req_o.pop = !stat_i.empty;
          style_d   = stat_i.empty ? '0 : stat_i.top;
          mode_d    = ModeSkip;
        end else begin
          req_o.push = !stat_i.full;
          if (byte_i == CharB) style_d = style_q | FlagBold;
          if (byte_i == CharI) style_d = style_q | FlagItalic;
          if (byte_i == CharC) begin
            style_d = style_q | FlagColor;
            mode_d  = ModeColon;
          end else if (byte_i == CharGt) mode_d = ModeText;
          else mode_d = ModeSkip;
        end
      end
      ModeColon: begin
        if (byte_i == CharColon) mode_d = ModeHash;
        else if (byte_i == CharGt) mode_d = ModeText;
        else mode_d = ModeSkip;
      end
      ModeHash: begin
        if (byte_i == CharHash) begin
          mode_d = ModeHex;
          hcnt_d = '0;
          hok_d  = 1'b1;
          pend_d = '0;
        end else if (byte_i == CharGt) mode_d = ModeText;
        else mode_d = ModeSkip;
      end
      ModeHex: begin
        if (byte_i == CharGt) begin
          mode_d = ModeText;
        end else begin
          if (!hex[4]) hok_d = 1'b0;
          else pend_d = {pend_q[19:0], hex[3:0]};
          hcnt_d = hcnt_q + 1'b1;
          if (hcnt_d >= HexDigits) mode_d = ModeHexEnd;
        end
      end
      ModeHexEnd: begin
        if (byte_i == CharGt) begin
          if (hok_q) color_d = pend_q;
          mode_d = ModeText;
        end else mode_d = ModeSkip;
      end
      ModeSkip: begin
        if (byte_i == CharGt) mode_d = ModeText;
      end
      default: mode_d = ModeText;
    endcase
    if (eos_i) begin
      mode_d      = ModeText;
      req_o.clear = 1'b1;
      hcnt_d      = '0;
      hok_d       = 1'b1;
    end
    if (!acc_i) begin
      req_o.push  = 1'b0;
      req_o.pop   = 1'b0;
      req_o.clear = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeText;
      style_q     <= '0;
      color_q     <= '0;
      pend_q      <= '0;
      hcnt_q      <= '0;
      hok_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (acc_i) begin
        mode_q      <= mode_d;
        style_q     <= style_d;
        color_q     <= color_d;
        pend_q      <= pend_d;
        hcnt_q      <= hcnt_d;
        hok_q       <= hok_d;
        out_valid_q <= emit;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, style and color as they stood before this byte
  always_ff @(posedge clk_i) begin
    if (acc_i && emit) begin
      glyph_q  <= byte_i;
      ostyle_q <= style_q;
      ocolor_q <= color_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign glyph_o     = glyph_q;
  assign style_o     = ostyle_q;
  assign color_o     = ocolor_q;

endmodule

// File: rtl/styled_text_tag_parser.sv
// ============================================================================
// styled_text_tag_parser: markup byte stream to styled glyphs
// Top level: stream ports, parser and style stack.
// ============================================================================
// A glyph is registered and appears in the cycle after its byte is taken.
// Throughput: one byte per cycle, pops and pushes included; the stack
//   memory's registered read is covered by a cached top entry and forwarding.
// Input is held off only while a finished glyph waits on m_axis_tready_i.
// Reset (rst_ni low, async): text mode, flags, color and stack count cleared;
//   stack memory contents are not cleared and need no clearing pass.
module styled_text_tag_parser
  import sttp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte requests
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] text_byte
  input  logic        s_axis_tlast_i,   // end_of_string
  // glyph requests
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [7:0] glyph, [15:8] red_level,
                                        // [23:16] green_level, [31:24] blue_level
  output logic [2:0]  m_axis_tuser_o    // [0] bold_on, [1] italic_on, [2] color_on
);

  stack_req_t  stack_req;
  stack_stat_t stack_stat;
  logic        acc;
  logic [7:0]  glyph;
  logic [2:0]  style;
  logic [23:0] color;

  // The result register frees up whenever its glyph is taken in the same
  // cycle, so a steady stream runs at full rate.
  assign s_axis_tready_o = !m_axis_tvalid_o || m_axis_tready_i;
  assign acc             = s_axis_tvalid_i && s_axis_tready_o;

  sttp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .byte_i      (s_axis_tdata_i),
    .eos_i       (s_axis_tlast_i),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stack_stat),
    .req_o       (stack_req),
    .out_valid_o (m_axis_tvalid_o),
    .glyph_o     (glyph),
    .style_o     (style),
    .color_o     (color)
  );

  // Style stack: push saves the flags on an opening tag, pop restores them.
  sttp_stack u_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (stack_req),
    .stat_o (stack_stat)
  );

  // flags live as {italic, bold, color}; tuser is {color, italic, bold}
  assign m_axis_tuser_o = {style[0], style[2], style[1]};
  assign m_axis_tdata_o = {color[7:0], color[15:8], color[23:16], glyph};

endmodule

// File: rtl/sttp_checker.sv
// ============================================================================
// sttp_checker: port-level checks for the styled text tag parser
// Watches the stream ports only; bound to the top level.
// ============================================================================
module sttp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [7:0]  s_axis_tdata_i,
  input logic        s_axis_tlast_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o
);

  logic in_acc;

  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  // glyph is fresh when the register was empty or just drained
  sequence s_out_new;
    m_axis_tvalid_o && (!$past(m_axis_tvalid_o) || $past(m_axis_tready_i));
  endsequence

  // an empty result register never stalls input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty result register");

  // every fresh glyph comes from the byte taken the cycle before
  a_new_from_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_out_new |-> $past(in_acc))
    else $error("glyph without a taken byte");

  a_glyph_is_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_out_new |-> m_axis_tdata_o[7:0] == $past(s_axis_tdata_i))
    else $error("glyph differs from its source byte");

  // a stalled glyph holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled glyph changed");

endmodule

bind styled_text_tag_parser sttp_checker u_sttp_checker (.*);

// File: tb/styled_text_tag_parser_tb.sv
// ============================================================================
// styled_text_tag_parser_tb: self-checking bench for the styled text parser
// Random marked-up strings with directed corner cases go in; every glyph that
// comes out is checked against a cycle-free model of the parser state.
// ============================================================================
module styled_text_tag_parser_tb
  import sttp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TotalItems  = 1650;
  localparam int unsigned RandomItems = 1500;  // after this, no idling at all
  localparam int unsigned HoldCycles  = 60;    // long sink hold-off
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned PrintCap    = 40;

  localparam logic [7:0] Digit0 = "0";
  localparam logic [7:0] LowerA = "a";
  localparam logic [7:0] UpperA = "A";
  localparam logic [7:0] Filler = "-";

  // parser modes of the prediction
  typedef enum logic [2:0] {
    PM_TEXT, PM_ESC, PM_TAG, PM_SKIP, PM_COLON, PM_HASH, PM_HEX, PM_HEXEND
  } parse_mode_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       bold;
    logic       italic;
    logic       color;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } glyph_t;

  // Holds the predicted parser state and the glyphs still owed by the block.
  class glyph_scoreboard;
    parse_mode_e       mode;
    logic [StyleW-1:0] style;
    logic [StyleW-1:0] saved [StackDepth];
    int unsigned       depth;
    logic [23:0]       color;
    logic [23:0]       pending;
    int unsigned       digits;
    bit                hex_ok;
    glyph_t            owed[$];
    int unsigned       errors;

    function new();
      mode    = PM_TEXT;
      style   = '0;
      depth   = 0;
      color   = '0;
      pending = '0;
      digits  = 0;
      hex_ok  = 1'b1;
      errors  = 0;
    endfunction

    static function int nibble_of(logic [7:0] b);
      if (b >= "0" && b <= "9") return int'(b) - 48;
      if (b >= "a" && b <= "f") return int'(b) - 87;
      if (b >= "A" && b <= "F") return int'(b) - 55;
      return -1;
    endfunction

    function void emit(logic [7:0] ch);
      glyph_t g;
      g.ch     = ch;
      g.bold   = (style & FlagBold) != 0;
      g.italic = (style & FlagItalic) != 0;
      g.color  = (style & FlagColor) != 0;
      g.red    = color[23:16];
      g.green  = color[15:8];
      g.blue   = color[7:0];
      owed     = {owed, g};
    endfunction

    // one accepted byte request
    function void note_byte(logic [7:0] b, bit last_byte);
      int nib;
      case (mode)
        PM_TEXT: begin
          if (b == CharLt) mode = PM_TAG;
          else if (b == CharPct && !last_byte) mode = PM_ESC;
          else emit(b);
        end
        PM_ESC: begin
          emit(b);
          mode = PM_TEXT;
        end
        PM_TAG: begin
          if (b == CharSlash) begin
            if (depth > 0) begin
              depth--;
              style = saved[depth];
            end else begin
              style = '0;
            end
            mode = PM_SKIP;
          end else begin
            // full stack drops the push, flags still change
            if (depth < StackDepth) begin
              saved[depth] = style;
              depth++;
            end
            if (b == CharB) style |= FlagBold;
            if (b == CharI) style |= FlagItalic;
            if (b == CharC) begin
              style |= FlagColor;
              mode = PM_COLON;
            end else if (b == CharGt) begin
              mode = PM_TEXT;
            end else begin
              mode = PM_SKIP;
            end
          end
        end
        PM_COLON: begin
          if (b == CharColon) mode = PM_HASH;
          else if (b == CharGt) mode = PM_TEXT;
          else mode = PM_SKIP;
        end
        PM_HASH: begin
          if (b == CharHash) begin
            mode    = PM_HEX;
            digits  = 0;
            hex_ok  = 1'b1;
            pending = '0;
          end else if (b == CharGt) begin
            mode = PM_TEXT;
          end else begin
            mode = PM_SKIP;
          end
        end
        PM_HEX: begin
          if (b == CharGt) begin
            mode = PM_TEXT;
          end else begin
            nib = nibble_of(b);
            if (nib < 0) hex_ok = 1'b0;
            else pending = {pending[19:0], 4'(nib)};
            digits++;
            if (digits >= HexDigits) mode = PM_HEXEND;
          end
        end
        PM_HEXEND: begin
          if (b == CharGt) begin
            if (hex_ok) color = pending;
            mode = PM_TEXT;
          end else begin
            mode = PM_SKIP;
          end
        end
        default: begin
          if (b == CharGt) mode = PM_TEXT;
        end
      endcase
      if (last_byte) begin
        mode   = PM_TEXT;
        depth  = 0;
        digits = 0;
        hex_ok = 1'b1;
      end
    endfunction

    task report_mismatch(string what);
      if (errors < PrintCap) $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    // one accepted glyph request
    task check_glyph(logic [31:0] data, logic [2:0] user);
      glyph_t want;
      if (owed.size() == 0) begin
        report_mismatch($sformatf("glyph %02h with nothing owed", data[7:0]));
      end else begin
        want = owed.pop_front();
        if (data[7:0] !== want.ch)
          report_mismatch($sformatf("glyph %02h, want %02h", data[7:0], want.ch));
        if (user[0] !== want.bold)
          report_mismatch($sformatf("bold %b, want %b", user[0], want.bold));
        if (user[1] !== want.italic)
          report_mismatch($sformatf("italic %b, want %b", user[1], want.italic));
        if (user[2] !== want.color)
          report_mismatch($sformatf("color_on %b, want %b", user[2], want.color));
        if (data[15:8] !== want.red)
          report_mismatch($sformatf("red %02h, want %02h", data[15:8], want.red));
        if (data[23:16] !== want.green)
          report_mismatch($sformatf("green %02h, want %02h", data[23:16], want.green));
        if (data[31:24] !== want.blue)
          report_mismatch($sformatf("blue %02h, want %02h", data[31:24], want.blue));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block under test
  // --------------------------------------------------------------------------
  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = '0;
  logic        s_axis_tlast_i  = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;

  always #1 clk_i = ~clk_i;

  styled_text_tag_parser uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  glyph_scoreboard board;
  int unsigned     bytes_sent    = 0;
  int unsigned     send_idle_pct = 0;   // chance of a gap after a byte
  int unsigned     sink_idle_pct = 0;   // chance of a stall burst on the sink
  bit              hold_req      = 1'b0;
  int unsigned     cycle_count   = 0;
  logic [7:0]      line_q[$];           // string being built

  // Runaway guard; sized far above the slowest legal run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // glyph sink: checks at the rising edge, moves tready at the falling edge.
  // A long hold-off is requested by the stimulus but counted here.
  // --------------------------------------------------------------------------
  initial begin : glyph_sink
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
        board.check_glyph(m_axis_tdata_o, m_axis_tuser_o);
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        m_axis_tready_i = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        m_axis_tready_i = 1'b0;
        stall_left--;
      end else if (sink_idle_pct != 0 && $urandom_range(99) < sink_idle_pct) begin
        m_axis_tready_i = 1'b0;
        stall_left      = $urandom_range(0, 7);  // stall burst, counted down in stall_left
      end else begin
        m_axis_tready_i = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // byte source
  // --------------------------------------------------------------------------

  // Offer one byte from a falling edge, hold it until taken, then maybe idle.
  task automatic send_byte(input logic [7:0] b, input bit last_byte, input bit may_idle);
    s_axis_tdata_i  = b;
    s_axis_tlast_i  = last_byte;
    s_axis_tvalid_i = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_byte(b, last_byte);
    bytes_sent++;
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    if (may_idle && send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
  endtask

  task automatic send_text(input string s, input bit ends_string);
    for (int k = 0; k < s.len(); k++)
      send_byte(s[k], ends_string && (k == s.len() - 1), 1'b1);
  endtask

  task automatic send_line();
    for (int k = 0; k < line_q.size(); k++)
      send_byte(line_q[k], k == line_q.size() - 1, 1'b1);
  endtask

  task automatic wait_drained();
    while (board.owed.size() != 0) @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // string builders
  // --------------------------------------------------------------------------
  function automatic void add_byte(logic [7:0] b);
    line_q = {line_q, b};
  endfunction

  function automatic void add_str(string s);
    for (int k = 0; k < s.len(); k++) add_byte(s[k]);
  endfunction

  function automatic logic [7:0] hex_char(int unsigned v, bit upper);
    if (v < 10) return Digit0 + 8'(v);
    return (upper ? UpperA : LowerA) + 8'(v - 10);
  endfunction

  function automatic logic [7:0] rand_hex();
    return hex_char($urandom_range(15), 1'($urandom_range(1)));
  endfunction

  // anything that is not a hex digit and does not close the tag
  function automatic logic [7:0] rand_non_hex();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (glyph_scoreboard::nibble_of(b) >= 0 || b == CharGt);
    return b;
  endfunction

  function automatic logic [7:0] rand_not(logic [7:0] a, logic [7:0] z);
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == a || b == z);
    return b;
  endfunction

  // style push tag: bold, italic or some other byte, maybe padded
  function automatic void add_open();
    int unsigned pick;
    pick = $urandom_range(9);
    add_byte(CharLt);
    if (pick < 4) add_byte(CharB);
    else if (pick < 8) add_byte(CharI);
    else add_byte(rand_not(CharGt, CharC));
    repeat ($urandom_range(0, 2)) add_byte(rand_not(CharGt, CharGt));
    add_byte(CharGt);
  endfunction

  function automatic void add_color_ok();
    add_str("<c:#");
    repeat (6) add_byte(rand_hex());
    add_byte(CharGt);
  endfunction

  // color tags that must leave the color alone
  function automatic void add_color_bad();
    int unsigned bad_at;
    case ($urandom_range(6))
      0: add_str("<c>");
      1: add_str("<c:>");
      2: begin  // too few digits, closed early
        add_str("<c:#");
        repeat ($urandom_range(0, 5)) add_byte(rand_hex());
        add_byte(CharGt);
      end
      3: begin  // one non-hex digit
        add_str("<c:#");
        bad_at = $urandom_range(5);
        for (int k = 0; k < 6; k++)
          add_byte(k == bad_at ? rand_non_hex() : rand_hex());
        add_byte(CharGt);
      end
      4: begin  // extra trailing character
        add_str("<c:#");
        repeat (6) add_byte(rand_hex());
        add_byte(rand_not(CharGt, CharGt));
        add_byte(CharGt);
      end
      5: begin
        add_str("<c");
        add_byte(rand_not(CharColon, CharGt));
        add_byte(CharGt);
      end
      default: begin
        add_str("<c:");
        add_byte(rand_not(CharHash, CharGt));
        add_byte(CharGt);
      end
    endcase
  endfunction

  function automatic void add_segment();
    int unsigned pick;
    logic [7:0]  b;
    pick = $urandom_range(99);
    if (pick < 40) begin            // printable text
      do b = 8'($urandom_range(8'h20, 8'h7E)); while (b == CharLt || b == CharPct);
      add_byte(b);
    end else if (pick < 48) begin   // escape and any byte
      add_byte(CharPct);
      add_byte(8'($urandom_range(255)));
    end else if (pick < 60) begin
      add_open();
    end else if (pick < 67) begin
      add_color_ok();
    end else if (pick < 73) begin
      add_color_bad();
    end else if (pick < 85) begin   // close tag, sometimes padded
      add_str("</");
      repeat ($urandom_range(0, 2)) add_byte(rand_not(CharGt, CharGt));
      add_byte(CharGt);
    end else if (pick < 94) begin   // raw noise byte
      add_byte(8'($urandom_range(255)));
    end else if (pick < 97) begin
      add_byte(CharGt);
    end else begin
      add_str("<>");
    end
  endfunction

  // One string: sometimes a deep nest that can overflow the stack, sometimes
  // cut short so that a tag may be left open at the end of the string.
  function automatic void build_line();
    bit deep;
    deep = ($urandom_range(9) == 0);
    line_q.delete();
    if (deep) repeat ($urandom_range(14, 20)) add_open();
    repeat ($urandom_range(1, 24)) add_segment();
    if (deep) repeat ($urandom_range(10, 22)) add_str("</>");
    if ($urandom_range(9) == 0)
      line_q = line_q[0:$urandom_range(0, line_q.size() - 1)];
  endfunction

  function automatic int unsigned idle_pick();
    case ($urandom_range(3))
      0: return 0;
      1: return 15;
      2: return 40;
      default: return 70;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned next_shuffle;
    bit          hold_done;
    bit          drain_done;
    next_shuffle = 0;
    hold_done    = 1'b0;
    drain_done   = 1'b0;
    board        = new();

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: byte extremes, stray '>', escaped '<', empty tag, italic push,
    // a full color load with mixed case, a pop, and a trailing '%'
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_text(">%<<>", 1'b0);
    send_text("<i>", 1'b0);
    send_text("<c:#aF09E1>", 1'b0);
    send_text("</>", 1'b0);
    send_text("%", 1'b1);

    while (bytes_sent < RandomItems) begin
      if (bytes_sent >= next_shuffle) begin
        send_idle_pct = idle_pick();
        sink_idle_pct = idle_pick();
        next_shuffle  = bytes_sent + 150;
      end
      // sink holds off while bytes keep coming: input must back up
      if (!hold_done && bytes_sent >= 500) begin
        hold_done = 1'b1;
        hold_req  = 1'b1;
        repeat (29) send_byte(Filler, 1'b0, 1'b0);
        send_byte(Filler, 1'b1, 1'b0);
      end
      // source pauses until every glyph is out
      if (!drain_done && bytes_sent >= 1000) begin
        drain_done = 1'b1;
        wait_drained();
      end
      build_line();
      send_line();
    end

    // tail runs at full rate on both sides
    send_idle_pct = 0;
    sink_idle_pct = 0;
    while (bytes_sent < TotalItems) begin
      build_line();
      send_line();
    end

    wait_drained();
    repeat (8) @(negedge clk_i);
    if (board.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
